// ===== design/bqeq_pkg.sv =====
// Shared constants, types and arithmetic helpers for the biquad equalizer.
package bqeq_pkg;

  localparam int MaxStages  = 8;
  localparam int NumSlots   = MaxStages * 5;
  localparam int StageW     = $clog2(MaxStages + 1);
  localparam int StageIdxW  = (MaxStages > 1) ? $clog2(MaxStages) : 1;
  localparam int CoefQ      = 28;
  localparam int SampleQ    = 10;
  localparam int GainQ      = 24;
  localparam logic [31:0] GainUnity = 32'd16777216;
  localparam logic [26:0] GainMax   = 27'd67108864;

  typedef enum logic [2:0] {
    REG_EQ_ENABLE    = 3'd0,
    REG_CHANNEL_MODE = 3'd1,
    REG_STAGE_COUNT  = 3'd2,
    REG_COEF_SELECT  = 3'd3,
    REG_COEF_VALUE   = 3'd4,
    REG_TARGET_GAIN  = 3'd5,
    REG_GAIN_STEP    = 3'd6,
    REG_FADE_FRAMES  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_MONO   = 2'd0,
    MODE_STEREO = 2'd1,
    MODE_MIX    = 2'd2
  } chan_mode_t;

  // Coefficient slot within one stage.
  typedef enum logic [2:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } coef_slot_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_UPD,
    ST_GAIN,
    ST_OUT
  } seq_state_t;

  // Control from the sequencer to each lane.
  typedef struct packed {
    logic                 load;    // take a new sample
    logic                 run;     // compute stage output
    logic                 upd;     // update stage memory, advance sample
    logic [StageIdxW-1:0] stage;
    logic                 gain;    // apply gain
    logic                 clear;   // clear filter memory
  } lane_ctl_t;

  // Round, shift by SampleQ, saturate to 16 bits.
  function automatic logic signed [15:0] finish16(input logic signed [63:0] y);
    logic signed [63:0] o;
    begin
      o = (y + 64'sd512) >>> SampleQ;
      if (o > 64'sd32767) finish16 = 16'sh7fff;
      else if (o < -64'sd32768) finish16 = 16'sh8000;
      else finish16 = o[15:0];
    end
  endfunction

endpackage

// ===== design/bqeq_lane.sv =====
// One channel lane: biquad stage steps on the shared sequencer control, then gain.
module bqeq_lane import bqeq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lane_ctl_t           ctl,
  input  logic signed [15:0]  sample,
  input  logic signed [31:0]  c0,
  input  logic signed [31:0]  c1,
  input  logic signed [31:0]  c2,
  input  logic signed [31:0]  c3,
  input  logic signed [31:0]  c4,
  input  logic signed [31:0]  gain,
  output logic signed [63:0]  y_out
);

  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] ys_r, ys_nxt;
  logic signed [63:0] y_r, y_nxt;
  logic        [63:0] d1_r [MaxStages];
  logic        [63:0] d2_r [MaxStages];
  logic signed [63:0] acc, p1, p3, p2, p4;
  logic signed [31:0] ys;
  logic signed [63:0] gp;

  assign acc = (64'(c0) * 64'(x_r)) + $signed(d1_r[ctl.stage]);
  assign ys  = 32'((acc + 64'sd134217728) >>> CoefQ);
  assign p1  = 64'(c1) * 64'(x_r);
  assign p3  = 64'(c3) * 64'(ys_r);
  assign p2  = 64'(c2) * 64'(x_r);
  assign p4  = 64'(c4) * 64'(ys_r);
  assign gp  = ((64'(x_r) * 64'(gain)) + 64'sd8388608) >>> GainQ;

  always_comb begin
    x_nxt  = x_r;
    ys_nxt = ys_r;
    y_nxt  = y_r;
    if (ctl.run) ys_nxt = ys;
    if (ctl.load) x_nxt = 32'(sample) <<< SampleQ;
    else if (ctl.upd) x_nxt = ys_r;
    if (ctl.gain) y_nxt = gp;
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    ys_r <= ys_nxt;
    y_r  <= y_nxt;
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < MaxStages; i++) begin
        d1_r[i] <= '0;
        d2_r[i] <= '0;
      end
    end else if (ctl.upd) begin
      d1_r[ctl.stage] <= 64'(p1 - p3) + d2_r[ctl.stage];
      d2_r[ctl.stage] <= 64'(p2 - p4);
    end
  end

  assign y_out = y_r;

endmodule

// ===== design/biquad_cascade_eq_with_gain_fade.sv =====
// Top level: two-lane biquad cascade equalizer with linear gain fade.
// With EQ running, an accepted input word passes RUN and UPD for each stage, then
// GAIN and OUT before out_tvalid; in bypass it goes from IDLE straight to GAIN. RUN
// computes a stage output, UPD updates its memory; this loop bounds the rate. One
// frame in flight: a new input word is taken only in IDLE, once OUT stored its result.
// Reset (rst_n, synchronous, low) clears configuration registers, coefficients, filter
// memory, unity gain, no fade, stereo mode; output register holds no word.
module biquad_cascade_eq_with_gain_fade import bqeq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // left_sample[15:0], right_sample[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // left_out[15:0], right_out[31:16], gain_now[59:32]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  seq_state_t state_r, state_nxt;
  logic [StageIdxW-1:0] stg_r, stg_nxt;

  logic        eq_en_r;
  logic [1:0]  mode_r;
  logic [StageW-1:0] nstg_r;
  logic [5:0]  csel_r;
  logic [26:0] tgt_r;
  logic signed [27:0] step_r;
  logic [31:0] gcur_r;
  logic [23:0] fade_r;
  // One small coefficient bank per slot, indexed by stage.
  logic signed [31:0] cb0_r [MaxStages];
  logic signed [31:0] cb1_r [MaxStages];
  logic signed [31:0] cb2_r [MaxStages];
  logic signed [31:0] ca1_r [MaxStages];
  logic signed [31:0] ca2_r [MaxStages];

  logic        ovalid_r;
  logic [63:0] odata_r;

  logic in_acc, clr, filt;
  lane_ctl_t ctl;
  logic signed [63:0] yl, yr, ml, mr;
  logic [3:0] wn;
  logic [StageIdxW-1:0] csel_stg;
  coef_slot_t csel_slot;

  // Split a coefficient select into stage and slot by compare and subtract.
  function automatic logic [StageIdxW-1:0] sel_stage(input logic [5:0] v);
    logic [StageIdxW-1:0] s_o;
    s_o = '0;
    for (int s = 0; s < MaxStages; s++)
      if (32'(v) >= 32'(s * 5)) s_o = StageIdxW'(s);
    return s_o;
  endfunction

  function automatic coef_slot_t sel_slot(input logic [5:0] v);
    logic [2:0] sl;
    sl = '0;
    for (int s = 0; s < MaxStages; s++)
      if (32'(v) >= 32'(s * 5)) sl = 3'(32'(v) - 32'(s * 5));
    return coef_slot_t'(sl);
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign filt      = eq_en_r && (nstg_r != '0);
  assign wn        = cfg_wdata[3:0];
  assign csel_stg  = sel_stage(csel_r);
  assign csel_slot = sel_slot(csel_r);

  // Memory clear on mode, stage count, coefficient writes and EQ enable rise.
  always_comb begin
    clr = 1'b0;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_EQ_ENABLE:    clr = cfg_wdata[0] && !eq_en_r;
        REG_CHANNEL_MODE: clr = 1'b1;
        REG_STAGE_COUNT:  clr = 1'b1;
        REG_COEF_VALUE:   clr = (32'(csel_r) < 32'(NumSlots));
        default:          clr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_en_r <= 1'b0;
      mode_r  <= MODE_STEREO;
      nstg_r  <= '0;
      csel_r  <= '0;
      tgt_r   <= 27'(GainUnity);
      step_r  <= '0;
      gcur_r  <= GainUnity;
      fade_r  <= '0;
      for (int i = 0; i < MaxStages; i++) begin
        cb0_r[i] <= '0;
        cb1_r[i] <= '0;
        cb2_r[i] <= '0;
        ca1_r[i] <= '0;
        ca2_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_EQ_ENABLE:    eq_en_r <= cfg_wdata[0];
          REG_CHANNEL_MODE: mode_r <= cfg_wdata[1:0];
          REG_STAGE_COUNT:
            nstg_r <= (32'(wn) > 32'(MaxStages)) ? StageW'(MaxStages) : StageW'(wn);
          REG_COEF_SELECT:  csel_r <= cfg_wdata[5:0];
          REG_COEF_VALUE: begin
            if (32'(csel_r) < 32'(NumSlots)) begin
              case (csel_slot)
                SLOT_B0: cb0_r[csel_stg] <= cfg_wdata;
                SLOT_B1: cb1_r[csel_stg] <= cfg_wdata;
                SLOT_B2: cb2_r[csel_stg] <= cfg_wdata;
                SLOT_A1: ca1_r[csel_stg] <= cfg_wdata;
                SLOT_A2: ca2_r[csel_stg] <= cfg_wdata;
                default: ;
              endcase
            end
          end
          REG_TARGET_GAIN:
            tgt_r <= (cfg_wdata[26:0] > GainMax) ? GainMax : cfg_wdata[26:0];
          REG_GAIN_STEP:    step_r <= cfg_wdata[27:0];
          REG_FADE_FRAMES: begin
            fade_r <= cfg_wdata[23:0];
            if (cfg_wdata[23:0] == '0) gcur_r <= 32'(tgt_r);
          end
          default: ;
        endcase
      end else if (in_acc && fade_r != '0) begin
        // Advance the fade one frame; land on target at the end.
        fade_r <= fade_r - 24'd1;
        if (fade_r == 24'd1) gcur_r <= 32'(tgt_r);
        else gcur_r <= gcur_r + 32'(step_r);
      end
    end
  end

  // Sequencer: load, stage output, stage update, gain, output.
  always_comb begin
    state_nxt = state_r;
    stg_nxt   = stg_r;
    ctl       = '0;
    ctl.stage = stg_r;
    ctl.clear = clr;
    case (state_r)
      ST_IDLE: if (in_acc) begin
        ctl.load  = 1'b1;
        stg_nxt   = '0;
        state_nxt = filt ? ST_RUN : ST_GAIN;
      end
      ST_RUN: begin
        ctl.run   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ctl.upd = 1'b1;
        stg_nxt = stg_r + 1'b1;
        if (StageW'(stg_r) + 1'b1 == nstg_r) state_nxt = ST_GAIN;
        else state_nxt = ST_RUN;
      end
      ST_GAIN: begin
        ctl.gain  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: if (!ovalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stg_r   <= '0;
    end else begin
      state_r <= state_nxt;
      stg_r   <= stg_nxt;
    end
  end

  bqeq_lane u_left (
    .clk, .rst_n, .ctl, .sample(in_tdata[15:0]),
    .c0(cb0_r[stg_r]), .c1(cb1_r[stg_r]), .c2(cb2_r[stg_r]),
    .c3(ca1_r[stg_r]), .c4(ca2_r[stg_r]),
    .gain(gcur_r), .y_out(yl)
  );

  bqeq_lane u_right (
    .clk, .rst_n, .ctl, .sample(in_tdata[31:16]),
    .c0(cb0_r[stg_r]), .c1(cb1_r[stg_r]), .c2(cb2_r[stg_r]),
    .c3(ca1_r[stg_r]), .c4(ca2_r[stg_r]),
    .gain(gcur_r), .y_out(yr)
  );

  // Merge lanes: mono, stereo or averaged.
  always_comb begin
    ml = yl;
    mr = yr;
    if (mode_r == MODE_MIX) begin
      ml = (yl + yr) >>> 1;
      mr = ml;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (state_r == ST_OUT && (!ovalid_r || out_tready)) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
    if (state_r == ST_OUT && (!ovalid_r || out_tready)) begin
      odata_r[15:0]  <= finish16(ml);
      odata_r[31:16] <= (mode_r == MODE_MONO) ? 16'd0 : finish16(mr);
      odata_r[59:32] <= gcur_r[27:0];
      odata_r[63:60] <= '0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule
